// ===== rtl/point_pair_distance_cutoff_top_defines.svh =====
// Assertion macros for the point pair distance block.
// Included by the modules that carry concurrent checks; needs signals clock and reset.
`ifndef POINT_PAIR_DISTANCE_CUTOFF_TOP_DEFINES_SVH
`define POINT_PAIR_DISTANCE_CUTOFF_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PPDC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ppdc check failed");

// Implication after a fixed number of clock edges.
`define PPDC_ASSERT_AFTER(label, ante, n, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##(n) (cons)) \
      else $error("ppdc latency check failed");

`endif

// ===== rtl/ppdc_pkg.sv =====
// Shared widths, types and register codes of the point pair distance block.
// No dependencies; used by every module through scoped names.
`timescale 1ns / 1ps

package ppdc_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int CUTOFF_W    = 31;
   localparam int DIST_W      = 33;

   // |difference| <= 2^COORD_WIDTH, so one bit more than a coordinate
   localparam int DIFF_W  = COORD_WIDTH + 1;
   localparam int SQ_W    = 2 * COORD_WIDTH + 1;
   localparam int SUM_W   = 2 * COORD_WIDTH + 2;
   localparam int ROOT_W  = SUM_W / 2;
   localparam int REM_W   = ROOT_W + 2;
   localparam int CELLS   = ROOT_W;
   localparam int CMP_W   = (DIFF_W > CUTOFF_W) ? DIFF_W : CUTOFF_W;
   localparam int SAT_W   = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;
   localparam int FRONT_STAGES = 3;
   // edges from the accepting edge to the edge that takes the result
   localparam int ACCEPT_TO_RSP = FRONT_STAGES + CELLS + 1;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUTOFF_ENABLE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUTOFF        = 1'd1;

   // sideband that travels with every beat along the pipeline
   typedef struct packed {
      logic                valid;
      logic                clipped;
      logic [CUTOFF_W-1:0] cutoff;
   } tag_type;

endpackage

// ===== rtl/ppdc_front.sv =====
// Front stages: axis differences with cutoff test, squares, and their sum.
// Depends on ppdc_pkg.
`timescale 1ns / 1ps

module ppdc_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  logic signed [ppdc_pkg::COORD_WIDTH-1:0] ref_x,
   input  logic signed [ppdc_pkg::COORD_WIDTH-1:0] ref_y,
   input  logic signed [ppdc_pkg::COORD_WIDTH-1:0] ref_z,
   input  logic signed [ppdc_pkg::COORD_WIDTH-1:0] other_x,
   input  logic signed [ppdc_pkg::COORD_WIDTH-1:0] other_y,
   input  logic signed [ppdc_pkg::COORD_WIDTH-1:0] other_z,
   input  logic                                  cutoff_enable,
   input  logic [ppdc_pkg::CUTOFF_W-1:0]         cutoff,
   output ppdc_pkg::tag_type                     tag_out,
   output logic [ppdc_pkg::SUM_W-1:0]            sum_out
);

   logic signed [ppdc_pkg::DIFF_W-1:0] delta [3];
   logic [ppdc_pkg::DIFF_W-1:0]        mag_in [3];
   logic [ppdc_pkg::DIFF_W-1:0]        mag_ff [3];
   logic [ppdc_pkg::SQ_W-1:0]          sq_in [3];
   logic [ppdc_pkg::SQ_W-1:0]          sq_ff [3];
   logic [ppdc_pkg::SUM_W-1:0]         sum_in;
   logic [ppdc_pkg::SUM_W-1:0]         sum_ff;
   logic                               over;
   ppdc_pkg::tag_type                  tag_a_in;
   ppdc_pkg::tag_type                  tag_a_ff;
   ppdc_pkg::tag_type                  tag_b_ff;
   ppdc_pkg::tag_type                  tag_c_ff;

   always_comb begin
      delta[0] = ppdc_pkg::DIFF_W'(ref_x) - ppdc_pkg::DIFF_W'(other_x);
      delta[1] = ppdc_pkg::DIFF_W'(ref_y) - ppdc_pkg::DIFF_W'(other_y);
      delta[2] = ppdc_pkg::DIFF_W'(ref_z) - ppdc_pkg::DIFF_W'(other_z);
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = delta[i][ppdc_pkg::DIFF_W-1] ? ppdc_pkg::DIFF_W'(-delta[i])
                                                  : ppdc_pkg::DIFF_W'(delta[i]);
      end
      over = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (ppdc_pkg::CMP_W'(mag_in[i]) > ppdc_pkg::CMP_W'(cutoff)) begin
            over = 1'b1;
         end
      end
      tag_a_in.valid   = load;
      tag_a_in.clipped = cutoff_enable & over;
      tag_a_in.cutoff  = cutoff;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = ppdc_pkg::SQ_W'({{ppdc_pkg::DIFF_W{1'b0}}, mag_ff[i]}
                                  * {{ppdc_pkg::DIFF_W{1'b0}}, mag_ff[i]});
      end
      sum_in = ppdc_pkg::SUM_W'(sq_ff[0]) + ppdc_pkg::SUM_W'(sq_ff[1])
             + ppdc_pkg::SUM_W'(sq_ff[2]);
   end

   // payload advances every cycle; only the tags need reset
   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      sq_ff  <= sq_in;
      sum_ff <= sum_in;
      if (reset) begin
         tag_a_ff <= '0;
         tag_b_ff <= '0;
         tag_c_ff <= '0;
      end else begin
         tag_a_ff <= tag_a_in;
         tag_b_ff <= tag_a_ff;
         tag_c_ff <= tag_b_ff;
      end
   end

   assign tag_out = tag_c_ff;
   assign sum_out = sum_ff;

endmodule

// ===== rtl/ppdc_sqrt_cell.sv =====
// One cell of the square root chain: retires one root bit per beat.
// Depends on ppdc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "point_pair_distance_cutoff_top_defines.svh"

module ppdc_sqrt_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  ppdc_pkg::tag_type              tag_in,
   input  logic [ppdc_pkg::SUM_W-1:0]     rad_in,
   input  logic [ppdc_pkg::ROOT_W-1:0]    root_in,
   input  logic [ppdc_pkg::REM_W-1:0]     rem_in,
   output ppdc_pkg::tag_type              tag_out,
   output logic [ppdc_pkg::SUM_W-1:0]     rad_out,
   output logic [ppdc_pkg::ROOT_W-1:0]    root_out,
   output logic [ppdc_pkg::REM_W-1:0]     rem_out
);

   logic [ppdc_pkg::REM_W-1:0]  rem_shift;
   logic [ppdc_pkg::REM_W-1:0]  trial;
   logic                        fits;
   logic [ppdc_pkg::REM_W-1:0]  rem_in_next;
   logic [ppdc_pkg::ROOT_W-1:0] root_in_next;
   logic [ppdc_pkg::SUM_W-1:0]  rad_in_next;
   ppdc_pkg::tag_type           tag_ff;
   logic [ppdc_pkg::SUM_W-1:0]  rad_ff;
   logic [ppdc_pkg::ROOT_W-1:0] root_ff;
   logic [ppdc_pkg::REM_W-1:0]  rem_ff;

   always_comb begin
      // bring down the next two radicand bits, try root*4+1
      rem_shift    = {rem_in[ppdc_pkg::REM_W-3:0], rad_in[ppdc_pkg::SUM_W-1 -: 2]};
      trial        = {root_in, 2'b01};
      fits         = (rem_shift >= trial);
      rem_in_next  = fits ? (rem_shift - trial) : rem_shift;
      root_in_next = {root_in[ppdc_pkg::ROOT_W-2:0], fits};
      rad_in_next  = {rad_in[ppdc_pkg::SUM_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in_next;
      root_ff <= root_in_next;
      rem_ff  <= rem_in_next;
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   assign tag_out  = tag_ff;
   assign rad_out  = rad_ff;
   assign root_out = root_ff;
   assign rem_out  = rem_ff;

   // partial remainder never exceeds twice the partial root
   `PPDC_ASSERT_NOW(a_rem_bound, tag_ff.valid,
                    rem_ff <= (ppdc_pkg::REM_W'(root_ff) << 1))

endmodule

// ===== rtl/point_pair_distance_cutoff_top.sv =====
// Top level of the point pair distance block: config registers, front stages,
// square root cell chain and result register. Depends on ppdc_pkg, ppdc_front, ppdc_sqrt_cell.
//
// Usage:
//   Input: drive the six signed Q16.16 coordinates on req_* and raise start;
//   the beat is taken at a rising edge where start is high and busy is low.
//   busy is high during reset and in the cycle right after it, low at all
//   other times, so one beat may enter on every clock.
//   Result: rsp_valid strobes for one cycle with rsp_distance (unsigned Q17.16,
//   floored) and rsp_clipped. Each beat passes three front stages
//   (differences, squares, sum), 33 root cells with one root bit each, and
//   the output register. One result per clock at most, in input order.
//   The receiver cannot stall the block; results are not held.
//   Config: csr_we with csr_index 0 writes cutoff_enable (bit 0 of csr_wdata),
//   index 1 writes the 31-bit cutoff. Write only with no beat in flight.
//   Reset (synchronous, active high) clears both registers and drops all
//   beats in flight; no rsp_valid follows a beat lost that way.
`timescale 1ns / 1ps
`include "point_pair_distance_cutoff_top_defines.svh"

module point_pair_distance_cutoff_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [ppdc_pkg::COORD_WIDTH-1:0] req_ref_x,
   input  logic signed [ppdc_pkg::COORD_WIDTH-1:0] req_ref_y,
   input  logic signed [ppdc_pkg::COORD_WIDTH-1:0] req_ref_z,
   input  logic signed [ppdc_pkg::COORD_WIDTH-1:0] req_other_x,
   input  logic signed [ppdc_pkg::COORD_WIDTH-1:0] req_other_y,
   input  logic signed [ppdc_pkg::COORD_WIDTH-1:0] req_other_z,
   output logic                                   rsp_valid,
   output logic [ppdc_pkg::DIST_W-1:0]            rsp_distance,
   output logic                                   rsp_clipped,
   input  logic                                   csr_we,
   input  logic [ppdc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [ppdc_pkg::CUTOFF_W-1:0]          csr_wdata
);

   logic                          busy_ff;
   logic                          cutoff_enable_ff;
   logic [ppdc_pkg::CUTOFF_W-1:0] cutoff_ff;
   logic                          accept;

   ppdc_pkg::tag_type             tag_chain  [ppdc_pkg::CELLS+1];
   logic [ppdc_pkg::SUM_W-1:0]    rad_chain  [ppdc_pkg::CELLS+1];
   logic [ppdc_pkg::ROOT_W-1:0]   root_chain [ppdc_pkg::CELLS+1];
   logic [ppdc_pkg::REM_W-1:0]    rem_chain  [ppdc_pkg::CELLS+1];

   logic [ppdc_pkg::SAT_W-1:0]    root_wide;
   logic [ppdc_pkg::DIST_W-1:0]   root_sat;
   logic                          rsp_valid_in;
   logic [ppdc_pkg::DIST_W-1:0]   rsp_distance_in;
   logic                          rsp_clipped_in;
   logic                          rsp_valid_ff;
   logic [ppdc_pkg::DIST_W-1:0]   rsp_distance_ff;
   logic                          rsp_clipped_ff;

   assign accept = start & ~busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff          <= 1'b1;
         cutoff_enable_ff <= 1'b0;
         cutoff_ff        <= '0;
      end else begin
         busy_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               ppdc_pkg::CSR_CUTOFF_ENABLE: cutoff_enable_ff <= csr_wdata[0];
               ppdc_pkg::CSR_CUTOFF:        cutoff_ff        <= csr_wdata;
               default:                     cutoff_ff        <= cutoff_ff;
            endcase
         end
      end
   end

   ppdc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .load          (accept),
      .ref_x         (req_ref_x),
      .ref_y         (req_ref_y),
      .ref_z         (req_ref_z),
      .other_x       (req_other_x),
      .other_y       (req_other_y),
      .other_z       (req_other_z),
      .cutoff_enable (cutoff_enable_ff),
      .cutoff        (cutoff_ff),
      .tag_out       (tag_chain[0]),
      .sum_out       (rad_chain[0])
   );

   assign root_chain[0] = '0;
   assign rem_chain[0]  = '0;

   for (genvar g = 0; g < ppdc_pkg::CELLS; g++) begin : g_cell
      ppdc_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .tag_in   (tag_chain[g]),
         .rad_in   (rad_chain[g]),
         .root_in  (root_chain[g]),
         .rem_in   (rem_chain[g]),
         .tag_out  (tag_chain[g+1]),
         .rad_out  (rad_chain[g+1]),
         .root_out (root_chain[g+1]),
         .rem_out  (rem_chain[g+1])
      );
   end

   always_comb begin
      // clamp the root to the field width
      root_wide = ppdc_pkg::SAT_W'(root_chain[ppdc_pkg::CELLS]);
      if (root_wide > ppdc_pkg::SAT_W'({ppdc_pkg::DIST_W{1'b1}})) begin
         root_sat = {ppdc_pkg::DIST_W{1'b1}};
      end else begin
         root_sat = root_wide[ppdc_pkg::DIST_W-1:0];
      end
      rsp_valid_in    = tag_chain[ppdc_pkg::CELLS].valid;
      rsp_clipped_in  = tag_chain[ppdc_pkg::CELLS].clipped;
      rsp_distance_in = rsp_clipped_in
                      ? ppdc_pkg::DIST_W'(tag_chain[ppdc_pkg::CELLS].cutoff)
                      : root_sat;
   end

   always_ff @(posedge clock) begin
      rsp_distance_ff <= rsp_distance_in;
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         rsp_clipped_ff <= 1'b0;
      end else begin
         rsp_valid_ff   <= rsp_valid_in;
         rsp_clipped_ff <= rsp_clipped_in & rsp_valid_in;
      end
   end

   assign busy         = busy_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_clipped  = rsp_clipped_ff;

   // every accepted beat comes out as a result strobe
   `PPDC_ASSERT_AFTER(a_beat_latency, start && !busy, ppdc_pkg::ACCEPT_TO_RSP, rsp_valid)
   // a result strobe is always backed by an accepted beat
   `PPDC_ASSERT_NOW(a_no_phantom, rsp_valid,
                    $past(start && !busy, ppdc_pkg::ACCEPT_TO_RSP))
   // a clipped result carries the cutoff, which fits in its narrower width
   `PPDC_ASSERT_NOW(a_clip_width, rsp_clipped,
                    rsp_valid && (rsp_distance[ppdc_pkg::DIST_W-1:ppdc_pkg::CUTOFF_W] == '0))

endmodule

// ===== test/point_pair_distance_cutoff_top_tb.sv =====
// Self-checking bench for point_pair_distance_cutoff_top: random bursts of point pairs,
// per-axis cutoff settings and an in-bench distance predictor. Depends on ppdc_pkg.
`timescale 1ns / 1ps

module point_pair_distance_cutoff_top_tb;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int RAND_PHASES  = 7;
   localparam int RAND_PER_SET = 200;

   typedef struct {
      logic signed [ppdc_pkg::COORD_WIDTH-1:0] ref_x;
      logic signed [ppdc_pkg::COORD_WIDTH-1:0] ref_y;
      logic signed [ppdc_pkg::COORD_WIDTH-1:0] ref_z;
      logic signed [ppdc_pkg::COORD_WIDTH-1:0] other_x;
      logic signed [ppdc_pkg::COORD_WIDTH-1:0] other_y;
      logic signed [ppdc_pkg::COORD_WIDTH-1:0] other_z;
   } pair_beat_type;

   typedef struct {
      logic [ppdc_pkg::DIST_W-1:0] distance;
      logic                        clipped;
   } dist_result_type;

   localparam logic signed [31:0] MAX_C = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MIN_C = 32'sh8000_0000;
   localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;
   localparam logic signed [31:0] LIM_Q = 32'sh0003_0000;
   localparam logic signed [31:0] OVR_Q = 32'sh0003_0001;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [ppdc_pkg::COORD_WIDTH-1:0] req_ref_x = '0;
   logic signed [ppdc_pkg::COORD_WIDTH-1:0] req_ref_y = '0;
   logic signed [ppdc_pkg::COORD_WIDTH-1:0] req_ref_z = '0;
   logic signed [ppdc_pkg::COORD_WIDTH-1:0] req_other_x = '0;
   logic signed [ppdc_pkg::COORD_WIDTH-1:0] req_other_y = '0;
   logic signed [ppdc_pkg::COORD_WIDTH-1:0] req_other_z = '0;
   logic rsp_valid;
   logic [ppdc_pkg::DIST_W-1:0] rsp_distance;
   logic rsp_clipped;
   logic csr_we = 1'b0;
   logic [ppdc_pkg::CSR_INDEX_W-1:0] csr_index = ppdc_pkg::CSR_CUTOFF_ENABLE;
   logic [ppdc_pkg::CUTOFF_W-1:0] csr_wdata = '0;

   pair_beat_type   pending_pairs[$];
   dist_result_type expected_dists[$];
   pair_beat_type   drive_pair;
   dist_result_type want;

   logic                          cutoff_on = 1'b0;
   logic [ppdc_pkg::CUTOFF_W-1:0] cutoff_level = '0;
   logic                          beat_taken = 1'b0;
   int                            mismatch_count = 0;
   int                            cycle_count = 0;
   int unsigned                   gap_left = 0;
   int unsigned                   burst_left = 8;

   point_pair_distance_cutoff_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_ref_x(req_ref_x), .req_ref_y(req_ref_y), .req_ref_z(req_ref_z),
      .req_other_x(req_other_x), .req_other_y(req_other_y), .req_other_z(req_other_z),
      .rsp_valid(rsp_valid), .rsp_distance(rsp_distance), .rsp_clipped(rsp_clipped),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [ppdc_pkg::DIFF_W-1:0] axis_span(input logic signed [31:0] a,
                                                              input logic signed [31:0] b);
      logic signed [ppdc_pkg::DIFF_W:0] d;
      d = a - b;
      if (d < 0) d = -d;
      return d[ppdc_pkg::DIFF_W-1:0];
   endfunction

   function automatic dist_result_type predict_distance(
         input logic signed [31:0] rx, input logic signed [31:0] ry,
         input logic signed [31:0] rz, input logic signed [31:0] ox,
         input logic signed [31:0] oy, input logic signed [31:0] oz);
      logic [ppdc_pkg::DIFF_W-1:0] dx, dy, dz;
      logic [65:0]                 sum_sq;
      logic [33:0]                 root, trial;
      dist_result_type             res;
      dx = axis_span(rx, ox);
      dy = axis_span(ry, oy);
      dz = axis_span(rz, oz);
      if (cutoff_on && (dx > cutoff_level || dy > cutoff_level || dz > cutoff_level)) begin
         res.distance = ppdc_pkg::DIST_W'(cutoff_level);
         res.clipped  = 1'b1;
         return res;
      end
      sum_sq = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy) + 66'(dz) * 66'(dz);
      // floor root, one bit at a time from the top
      root = '0;
      for (int b = 33; b >= 0; b--) begin
         trial = root | (34'd1 << b);
         if (68'(trial) * 68'(trial) <= 68'(sum_sq)) root = trial;
      end
      res.distance = root[33] ? '1 : root[ppdc_pkg::DIST_W-1:0];
      res.clipped  = 1'b0;
      return res;
   endfunction

   function automatic void queue_pair(input logic signed [31:0] rx, input logic signed [31:0] ry,
                                      input logic signed [31:0] rz, input logic signed [31:0] ox,
                                      input logic signed [31:0] oy, input logic signed [31:0] oz);
      pair_beat_type p;
      p.ref_x = rx;   p.ref_y = ry;   p.ref_z = rz;
      p.other_x = ox; p.other_y = oy; p.other_z = oz;
      pending_pairs.push_back(p);
   endfunction

   // One axis: wide random, up to, at or one above the cutoff, tiny, medium (up to 2^20), or corner values.
   function automatic void pick_axis(output logic signed [31:0] a,
                                     output logic signed [31:0] b);
      logic signed [31:0] corners[5];
      longint             mag, base, far_end;
      int unsigned        sel;
      corners = '{MAX_C, MIN_C, 32'sd0, -32'sd1, 32'sd1};
      sel = $urandom_range(0, 9);
      if (sel <= 2) begin
         a = $urandom;
         b = $urandom;
      end else if (sel == 8) begin
         a = corners[$urandom_range(0, 4)];
         b = corners[$urandom_range(0, 4)];
      end else begin
         case (sel)
            3, 4: mag = longint'($urandom_range(0, cutoff_level));
            5: mag = longint'(cutoff_level);
            6: mag = longint'(cutoff_level) + 1;
            7: mag = longint'($urandom_range(0, 255));
            default: mag = longint'($urandom_range(0, 1 << 20));
         endcase
         if ($urandom_range(0, 1) == 1) mag = -mag;
         base = longint'(int'($urandom));
         far_end = base + mag;
         // flip direction if the far end leaves the coordinate range
         if (far_end > 64'sd2147483647 || far_end < -64'sd2147483648) far_end = base - mag;
         a = far_end[31:0];
         b = base[31:0];
      end
   endfunction

   task automatic write_reg(input logic [ppdc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [ppdc_pkg::CUTOFF_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == ppdc_pkg::CSR_CUTOFF_ENABLE) cutoff_on = value[0];
      else cutoff_level = value;
   endtask

   task automatic set_mode(input logic en, input logic [ppdc_pkg::CUTOFF_W-1:0] level);
      logic [ppdc_pkg::CUTOFF_W-2:0] junk;
      junk = (ppdc_pkg::CUTOFF_W-1)'($urandom);
      // upper bits of the enable write are don't-care; drive them random
      write_reg(ppdc_pkg::CSR_CUTOFF_ENABLE, {junk, en});
      write_reg(ppdc_pkg::CSR_CUTOFF, level);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_pairs.size() != 0 || start || expected_dists.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Sender: bursts of random length, random gaps, hold a beat until taken.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_taken) begin
         if (gap_left != 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_pairs.size() != 0) begin
            drive_pair = pending_pairs.pop_front();
            req_ref_x   <= drive_pair.ref_x;
            req_ref_y   <= drive_pair.ref_y;
            req_ref_z   <= drive_pair.ref_z;
            req_other_x <= drive_pair.other_x;
            req_other_y <= drive_pair.other_y;
            req_other_z <= drive_pair.other_z;
            start <= 1'b1;
            if (burst_left != 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 32);
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: gap_left = 0;
                  4, 5, 6, 7: gap_left = $urandom_range(1, 3);
                  default:    gap_left = $urandom_range(4, 40);
               endcase
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: check results against the oldest prediction, then log new beats.
   always @(posedge clock) begin
      cycle_count++;
      beat_taken <= !reset && start && !busy;
      if (!reset && rsp_valid) begin
         if (expected_dists.size() == 0) begin
            $error("unexpected result beat: distance %h clipped %0b", rsp_distance, rsp_clipped);
            mismatch_count++;
         end else begin
            want = expected_dists.pop_front();
            if (rsp_distance !== want.distance) begin
               $error("distance: expected %h, got %h", want.distance, rsp_distance);
               mismatch_count++;
            end
            if (rsp_clipped !== want.clipped) begin
               $error("clipped: expected %0b, got %0b", want.clipped, rsp_clipped);
               mismatch_count++;
            end
         end
      end
      if (!reset && start && !busy)
         expected_dists.push_back(predict_distance(req_ref_x, req_ref_y, req_ref_z,
                                                   req_other_x, req_other_y, req_other_z));
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("point_pair_distance_cutoff_top regression: fail");
         $finish;
      end
   end

   initial begin
      logic                          en_set[RAND_PHASES];
      logic [ppdc_pkg::CUTOFF_W-1:0] level_set[RAND_PHASES];
      logic signed [31:0]            ax, bx, ay, by, az, bz;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // plain distance with registers at reset
      queue_pair(0, 0, 0, 0, 0, 0);
      queue_pair(MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, MIN_C);
      queue_pair(MIN_C, MIN_C, MIN_C, MAX_C, MAX_C, MAX_C);
      queue_pair(MIN_C, MIN_C, MIN_C, 0, 0, 0);
      queue_pair(3 * ONE_Q, 4 * ONE_Q, 0, 0, 0, 0);
      queue_pair(1, 0, 0, 0, 0, 0);
      queue_pair(0, -5 * ONE_Q, 0, 0, 7 * ONE_Q, 0);
      queue_pair(0, 0, MAX_C, 0, 0, -32'sd1);
      queue_pair(-32'sd1, -32'sd1, -32'sd1, 1, 1, 1);
      ax = $urandom; ay = $urandom; az = $urandom;
      queue_pair(ax, ay, az, ax, ay, az);
      wait_drained();

      // per-axis limit of 3.0: equal passes, one LSB more clips
      set_mode(1'b1, LIM_Q[ppdc_pkg::CUTOFF_W-1:0]);
      queue_pair(LIM_Q, 0, 0, 0, 0, 0);
      queue_pair(0, 0, 0, LIM_Q, LIM_Q, LIM_Q);
      queue_pair(OVR_Q, 0, 0, 0, 0, 0);
      queue_pair(0, 0, 0, 0, OVR_Q, 0);
      queue_pair(0, 0, OVR_Q, 0, 0, 0);
      queue_pair(MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, MIN_C);
      wait_drained();

      set_mode(1'b1, '0);
      queue_pair(0, 0, 0, 0, 0, 0);
      queue_pair(0, 0, 1, 0, 0, 0);
      wait_drained();

      set_mode(1'b1, '1);
      queue_pair(MAX_C, 0, 0, 0, 0, 0);
      queue_pair(0, MIN_C, 0, 0, 0, 0);
      queue_pair(MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, MIN_C);
      wait_drained();

      // limit disabled: an over-limit axis gives the plain distance
      set_mode(1'b0, LIM_Q[ppdc_pkg::CUTOFF_W-1:0]);
      queue_pair(OVR_Q, 0, 0, 0, 0, 0);
      wait_drained();

      en_set[0] = 1'b0; level_set[0] = ppdc_pkg::CUTOFF_W'($urandom);
      en_set[1] = 1'b1; level_set[1] = '1;
      en_set[2] = 1'b1; level_set[2] = '0;
      en_set[3] = 1'b1; level_set[3] = ppdc_pkg::CUTOFF_W'($urandom_range(1 << 16, 1 << 24));
      en_set[4] = 1'b1; level_set[4] = ppdc_pkg::CUTOFF_W'($urandom);
      en_set[5] = 1'b0; level_set[5] = '1;
      en_set[6] = 1'b1; level_set[6] = ppdc_pkg::CUTOFF_W'($urandom_range(0, 1 << 16));

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         set_mode(en_set[ph], level_set[ph]);
         for (int n = 0; n < RAND_PER_SET; n++) begin
            pick_axis(ax, bx);
            pick_axis(ay, by);
            pick_axis(az, bz);
            queue_pair(ax, ay, az, bx, by, bz);
         end
         wait_drained();
      end

      repeat (ppdc_pkg::ACCEPT_TO_RSP + 8) @(posedge clock);
      if (mismatch_count == 0 && expected_dists.size() == 0) begin
         $display("point_pair_distance_cutoff_top regression: pass");
      end else begin
         $display("point_pair_distance_cutoff_top regression: fail");
      end
      $finish;
   end

endmodule
